FILE: hw/rtl/npcm_pkg.sv
// Package for the nearest palette color match block.
// Holds field widths, command codes and small color helpers.
// No dependencies; compile first.
package npcm_pkg;

    localparam int NPCM_ENTRIES = 256;

    localparam int IDX_W   = 8;
    localparam int CH_W    = 8;
    localparam int COLOR_W = 15;
    localparam int WORD_W  = 32;
    localparam int DIST_W  = 18;
    localparam int RGB_W   = 24;
    localparam int SQ_W    = 16;
    localparam int COMP_W  = 5;

    localparam logic [IDX_W-1:0]  TRANSPARENT_INDEX = 8'd255;
    localparam logic [CH_W-1:0]   OPAQUE_ALPHA      = 8'hFF;
    localparam logic [CH_W-1:0]   CLEAR_ALPHA       = 8'h00;
    localparam logic [DIST_W-1:0] DIST_INIT         = '1;
    localparam logic [DIST_W-1:0] MAX_DIST          = 18'd195075;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // Expand a 5-bit component to c*8+4.
    function automatic logic [CH_W-1:0] expand5(input logic [COMP_W-1:0] c);
        return {c, 3'b100};
    endfunction

    // Squared absolute difference of two 8-bit components.
    function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

FILE: hw/rtl/npcm_if.sv
// Channel interfaces for the nearest palette color match block.
// Request and response words with valid/ready handshake.
// Depends on npcm_pkg.
interface npcm_req_if
    import npcm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [IDX_W-1:0]     entry_index;
    logic [CH_W-1:0]      red;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      blue;
    logic [COLOR_W-1:0]   query_color;

    modport source (output valid, cmd, entry_index, red, green, blue, query_color,
                    input ready);
    modport sink   (input valid, cmd, entry_index, red, green, blue, query_color,
                    output ready);
endinterface

interface npcm_rsp_if
    import npcm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [IDX_W-1:0]     nearest_index;
    logic [WORD_W-1:0]    packed_entry;
    logic [DIST_W-1:0]    min_distance;

    modport source (output valid, nearest_index, packed_entry, min_distance,
                    input ready);
    modport sink   (input valid, nearest_index, packed_entry, min_distance,
                    output ready);
endinterface

FILE: hw/rtl/nearest_palette_color_match.sv
// Nearest palette color match: palette store, scan sequencer and distance unit.
// Depends on npcm_pkg and the channel interfaces in npcm_if.sv.
//
//   channel | dir | word carries
//   --------+-----+------------------------------------------------------------
//   req     | in  | cmd, entry_index, red, green, blue, query_color
//   rsp     | out | nearest_index, packed_entry, min_distance
//
// A write word stores one entry and returns its packed ABGR word in the cycle
// after acceptance. A query word runs a scan of the palette to its result:
// the palette memory has one read port, so the scan reads one entry per cycle,
// followed by draining the square and compare stages and then loading the
// response register once it is free.
// req.ready is high only while the sequencer is idle and the response register
// is free or being drained; a stalled response holds its word and a finished
// scan waits for the register. Reset clears control state only; the palette
// holds garbage until written.
module nearest_palette_color_match
    import npcm_pkg::*;
#(
    parameter int PALETTE_ENTRIES = NPCM_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    npcm_req_if.sink    req,
    npcm_rsp_if.source  rsp
);

    localparam int AW    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // Palette store: blue, green, red.
    logic [RGB_W-1:0] mem [PALETTE_ENTRIES];

    logic [CNT_W-1:0] scan_cnt_reg;
    logic             rd_valid_reg, rd_last_reg;
    logic [AW-1:0]    rd_idx_reg;
    logic [RGB_W-1:0] rd_data_reg;

    logic             p1_valid_reg, p1_last_reg;
    logic [AW-1:0]    p1_idx_reg;
    logic [SQ_W-1:0]  sq_r_reg, sq_g_reg, sq_b_reg;

    logic [CH_W-1:0]  qr_reg, qg_reg, qb_reg;
    logic [AW-1:0]    best_idx_reg;
    logic [DIST_W-1:0] best_dist_reg;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic [WORD_W-1:0] out_packed_reg;
    logic [DIST_W-1:0] out_dist_reg;

    logic              req_fire;
    logic              out_free;
    logic              issue;
    logic              issue_last;
    logic              wr_in_range;
    logic [RGB_W-1:0]  wr_rgb;
    logic [CH_W-1:0]   wr_alpha;
    logic [DIST_W-1:0] dist_sum;
    logic              better;

    assign out_free    = !out_valid_reg || rsp.ready;
    assign req.ready   = (state_reg == S_IDLE) && out_free;
    assign req_fire    = req.valid && req.ready;

    assign issue       = (state_reg == S_SCAN);
    assign issue_last  = issue && (scan_cnt_reg == CNT_W'(PALETTE_ENTRIES - 1));

    assign wr_in_range = ({1'b0, req.entry_index} < (IDX_W + 1)'(PALETTE_ENTRIES));
    assign wr_rgb      = {req.blue, req.green, req.red};
    // Entry 255 is the transparent one.
    assign wr_alpha    = (req.entry_index == TRANSPARENT_INDEX) ? CLEAR_ALPHA
                                                                 : OPAQUE_ALPHA;

    // Shared distance unit, compare half.
    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    // Strict less-than keeps the lowest index on a tie.
    assign better   = dist_sum < best_dist_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.cmd == CMD_QUERY))
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (issue_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (p1_valid_reg && p1_last_reg)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state, pipeline flags and the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_cnt_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            p1_valid_reg   <= 1'b0;
            p1_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_packed_reg <= '0;
            out_dist_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            rd_last_reg  <= issue_last;
            p1_valid_reg <= rd_valid_reg;
            p1_last_reg  <= rd_last_reg;

            if (req_fire)
                scan_cnt_reg <= '0;
            else if (issue)
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);

            // Load a new response when ready, else drop the old one once taken.
            if (req_fire && (req.cmd == CMD_WRITE))
            begin
                out_valid_reg  <= 1'b1;
                out_index_reg  <= '0;
                out_packed_reg <= {wr_alpha, wr_rgb};
                out_dist_reg   <= '0;
            end
            else if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg  <= 1'b1;
                out_index_reg  <= IDX_W'(best_idx_reg);
                out_packed_reg <= '0;
                out_dist_reg   <= best_dist_reg;
            end
            else if (rsp.ready)
            begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (req_fire && (req.cmd == CMD_WRITE) && wr_in_range)
            mem[req.entry_index[AW-1:0]] <= wr_rgb;
        if (issue)
            rd_data_reg <= mem[scan_cnt_reg[AW-1:0]];
    end

    // Scan datapath: square stage, then sum and compare against the best.
    always_ff @(posedge clk)
    begin
        if (issue)
            rd_idx_reg <= scan_cnt_reg[AW-1:0];

        if (rd_valid_reg)
        begin
            p1_idx_reg <= rd_idx_reg;
            sq_r_reg   <= sq_diff(qr_reg, rd_data_reg[CH_W-1:0]);
            sq_g_reg   <= sq_diff(qg_reg, rd_data_reg[2*CH_W-1:CH_W]);
            sq_b_reg   <= sq_diff(qb_reg, rd_data_reg[3*CH_W-1:2*CH_W]);
        end

        if (req_fire && (req.cmd == CMD_QUERY))
        begin
            qr_reg        <= expand5(req.query_color[COMP_W-1:0]);
            qg_reg        <= expand5(req.query_color[2*COMP_W-1:COMP_W]);
            qb_reg        <= expand5(req.query_color[3*COMP_W-1:2*COMP_W]);
            best_idx_reg  <= '0;
            best_dist_reg <= DIST_INIT;
        end
        else if (p1_valid_reg && better)
        begin
            best_idx_reg  <= p1_idx_reg;
            best_dist_reg <= dist_sum;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.nearest_index = out_index_reg;
    assign rsp.packed_entry  = out_packed_reg;
    assign rsp.min_distance  = out_dist_reg;

    // The scan never reads past the end of the palette.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_cnt_reg < CNT_W'(PALETTE_ENTRIES)))
        else $error("scan counter beyond palette");

    // A scan finishes only after the last entry went through the compare stage.
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_DONE) |-> $past(p1_valid_reg && p1_last_reg))
        else $error("scan finished before last entry compared");

    // A finished scan always holds a real distance.
    a_best_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (best_dist_reg <= MAX_DIST))
        else $error("best distance out of range at end of scan");

endmodule
